// File: rtl/core/syntax_highlight_classifier_core_assert.svh
// Assertion macros shared by the classifier RTL.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef SYNTAX_HIGHLIGHT_CLASSIFIER_CORE_ASSERT_SVH
`define SYNTAX_HIGHLIGHT_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Plain property that must hold at every clock edge out of reset.
`define SHLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("shlc assertion failed");

// Same-cycle implication.
`define SHLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("shlc implication failed");

// Next-cycle implication.
`define SHLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("shlc next-cycle implication failed");

`else

`define SHLC_ASSERT(lbl, clk, rstn, prop)
`define SHLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SHLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/shlc_pkg.sv
`timescale 1ns / 1ps

package shlc_pkg;

    // Longest delimiter the lexer honors; a register holds at most two characters.
    localparam int DELIM_MAX = 2;
    localparam int DELIM_LIMIT_I = (DELIM_MAX < 2) ? DELIM_MAX : 2;
    localparam logic [1:0] DELIM_LIMIT = 2'(DELIM_LIMIT_I);

    // Output queue between the lexer and the result channel.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CHARS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CHARS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CHARS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEN     = 3'd6;

    // Feature flag bit positions.
    localparam int FLAG_STRING = 0;
    localparam int FLAG_NUMBER = 1;

    // Character codes the lexer looks for.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;

    typedef enum logic [2:0] {
        CLS_NORMAL,
        CLS_LINE,
        CLS_BLOCK,
        CLS_STRING,
        CLS_NUMBER
    } cls_t;

    typedef enum logic [1:0] {
        QUOTE_NONE,
        QUOTE_DOUBLE,
        QUOTE_SINGLE
    } quote_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_row;
        logic       first_row;
    } in_item_t;

    typedef struct packed {
        logic [2:0] char_class;
        logic       open_comment;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  feature_flags;
        logic [15:0] line_chars;
        logic [1:0]  line_len;
        logic [15:0] open_chars;
        logic [1:0]  open_len;
        logic [15:0] close_chars;
        logic [1:0]  close_len;
    } cfg_t;

    // Lexer state carried from one character to the next.
    typedef struct packed {
        logic   in_block;
        quote_t quote;
        logic   after_sep;
        cls_t   prev_class;
        logic   forced_cnt;
        cls_t   forced_class;
        logic   rest_row;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        in_block:     1'b0,
        quote:        QUOTE_NONE,
        after_sep:    1'b1,
        prev_class:   CLS_NORMAL,
        forced_cnt:   1'b0,
        forced_class: CLS_NORMAL,
        rest_row:     1'b0
    };

    localparam cfg_t CFG_RESET = '0;

    // Effective delimiter length, clipped to what the lexer supports.
    function automatic logic [1:0] eff_len(input logic [1:0] len);
        logic [1:0] l;
        l = len;
        if (l > DELIM_LIMIT) begin
            l = DELIM_LIMIT;
        end
        return l;
    endfunction

    // A delimiter matches the current character and, for two characters, the next one.
    function automatic logic delim_hit(input logic [15:0] chars, input logic [1:0] len,
                                       input logic [7:0] c, input logic [7:0] n,
                                       input logic nv);
        logic [1:0] l;
        l = eff_len(len);
        return (l != 2'd0) && (c == chars[7:0]) &&
               ((l < 2'd2) || (nv && (n == chars[15:8])));
    endfunction

    // Whitespace, zero and punctuation that separate words.
    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c)
            8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: r = 1'b1;
            // , . ( ) + - / *
            8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A: r = 1'b1;
            // = ~ % < > [ ] ;
            8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/shlc_classify.sv
`timescale 1ns / 1ps

module shlc_classify (
    input  shlc_pkg::cfg_t       cfg,
    input  shlc_pkg::lex_state_t st_in,
    input  logic [7:0]           cur_char,
    input  logic [7:0]           next_char,
    input  logic                 next_valid,
    output shlc_pkg::cls_t       cls,
    output shlc_pkg::lex_state_t st_out
);
    import shlc_pkg::*;

    logic line_hit;
    logic open_hit;
    logic close_hit;
    logic block_en;
    logic is_digit;
    logic quote_close;

    // Delimiter matches against the current character and its lookahead.
    assign line_hit  = delim_hit(cfg.line_chars, cfg.line_len, cur_char, next_char,
                                 next_valid);
    assign open_hit  = delim_hit(cfg.open_chars, cfg.open_len, cur_char, next_char,
                                 next_valid);
    assign close_hit = delim_hit(cfg.close_chars, cfg.close_len, cur_char, next_char,
                                 next_valid);
    assign block_en  = (eff_len(cfg.open_len) != 2'd0) && (eff_len(cfg.close_len) != 2'd0);
    assign is_digit  = (cur_char >= CHAR_ZERO) && (cur_char <= CHAR_NINE);
    assign quote_close = ((st_in.quote == QUOTE_DOUBLE) && (cur_char == CHAR_DQUOTE)) ||
                         ((st_in.quote == QUOTE_SINGLE) && (cur_char == CHAR_SQUOTE));

    // Priority chain: forced class, rest of row, line comment, block comment,
    // string body, string start, number, ordinary character.
    always_comb begin
        st_out = st_in;
        cls    = CLS_NORMAL;
        if (st_in.forced_cnt) begin
            st_out.forced_cnt = 1'b0;
            cls = st_in.forced_class;
        end else if (st_in.rest_row) begin
            cls = CLS_LINE;
        end else if (line_hit && (st_in.quote == QUOTE_NONE) && !st_in.in_block) begin
            st_out.rest_row = 1'b1;
            cls = CLS_LINE;
        end else if (block_en && (st_in.quote == QUOTE_NONE) &&
                     (st_in.in_block || open_hit)) begin
            cls = CLS_BLOCK;
            if (st_in.in_block) begin
                if (close_hit) begin
                    st_out.in_block  = 1'b0;
                    st_out.after_sep = 1'b1;
                    if (eff_len(cfg.close_len) == 2'd2) begin
                        st_out.forced_cnt   = 1'b1;
                        st_out.forced_class = CLS_BLOCK;
                    end
                end
            end else begin
                st_out.in_block = 1'b1;
                if (eff_len(cfg.open_len) == 2'd2) begin
                    st_out.forced_cnt   = 1'b1;
                    st_out.forced_class = CLS_BLOCK;
                end
            end
        end else if (cfg.feature_flags[FLAG_STRING] && (st_in.quote != QUOTE_NONE)) begin
            cls = CLS_STRING;
            if ((cur_char == CHAR_BACKSLASH) && next_valid) begin
                st_out.forced_cnt   = 1'b1;
                st_out.forced_class = CLS_STRING;
            end else begin
                if (quote_close) begin
                    st_out.quote = QUOTE_NONE;
                end
                st_out.after_sep = 1'b1;
            end
        end else if (cfg.feature_flags[FLAG_STRING] &&
                     ((cur_char == CHAR_DQUOTE) || (cur_char == CHAR_SQUOTE))) begin
            st_out.quote = (cur_char == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
            cls = CLS_STRING;
        end else if (cfg.feature_flags[FLAG_NUMBER] && is_digit &&
                     (st_in.after_sep || (st_in.prev_class == CLS_NUMBER))) begin
            cls = CLS_NUMBER;
            st_out.after_sep = 1'b0;
        end else begin
            st_out.after_sep = is_sep(cur_char);
            cls = CLS_NORMAL;
        end
        st_out.prev_class = cls;
    end

endmodule

// File: rtl/core/syntax_highlight_classifier_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake         | Payload (shlc_pkg type)
// ----------+-------------------+------------------------------------------
// input     | s_valid / s_ready | s_data : in_item_t  (character, row flags)
// result    | m_valid / m_ready | m_data : out_item_t (class, open, last)
// config    | cfg_wr_en         | cfg_index, cfg_wdata, no read-back
//
// One item is taken per cycle while s_ready is high; the results it releases
// go to a four-entry result queue in the same edge and can leave the cycle after.
// A row's final item yields up to two results, so the result port (one per cycle
// if m_ready is high) sets the pace: s_ready is high while two entries are free.
// Reset is synchronous and active low; it clears the lexer state, the pending
// character flag, the queue pointers and the configuration. No clearing pass.
// A stalled result port only fills the queue; no result is dropped.

module syntax_highlight_classifier_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  shlc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output shlc_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [shlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shlc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import shlc_pkg::*;

    `include "syntax_highlight_classifier_core_assert.svh"

    cfg_t       cfg_reg, cfg_next;
    lex_state_t lex_reg, lex_next;
    logic [7:0] pend_char_reg;
    logic       pend_valid_reg, pend_valid_next;

    out_item_t             q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    cnt_reg, cnt_next;

    logic       in_fire;
    logic       out_fire;
    lex_state_t row_state;
    lex_state_t st_a, st_mid, st_b;
    cls_t       cls_a, cls_b;
    out_item_t  res_a, res_b;
    logic       push_a, push_b;
    logic [Q_PTR_W-1:0] wr_ptr_b;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    // Configuration writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FEATURE_FLAGS: cfg_next.feature_flags = cfg_wdata[1:0];
                CFG_LINE_CHARS:    cfg_next.line_chars    = cfg_wdata[15:0];
                CFG_LINE_LEN:      cfg_next.line_len      = cfg_wdata[1:0];
                CFG_OPEN_CHARS:    cfg_next.open_chars    = cfg_wdata[15:0];
                CFG_OPEN_LEN:      cfg_next.open_len      = cfg_wdata[1:0];
                CFG_CLOSE_CHARS:   cfg_next.close_chars   = cfg_wdata[15:0];
                CFG_CLOSE_LEN:     cfg_next.close_len     = cfg_wdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // State seen by the first character of a row.
    always_comb begin
        row_state = LEX_RESET;
        row_state.in_block = s_data.first_row ? 1'b0 : lex_reg.in_block;
    end

    // The held character, classified with the incoming one as lookahead.
    shlc_classify u_cls_pend (
        .cfg        (cfg_reg),
        .st_in      (lex_reg),
        .cur_char   (pend_char_reg),
        .next_char  (s_data.character),
        .next_valid (1'b1),
        .cls        (cls_a),
        .st_out     (st_a)
    );

    assign st_mid = pend_valid_reg ? st_a : row_state;

    // The row's final character, classified with no lookahead.
    shlc_classify u_cls_last (
        .cfg        (cfg_reg),
        .st_in      (st_mid),
        .cur_char   (s_data.character),
        .next_char  (8'h00),
        .next_valid (1'b0),
        .cls        (cls_b),
        .st_out     (st_b)
    );

    // Results and lexer state update for one accepted item.
    always_comb begin
        res_a.char_class   = cls_a;
        res_a.open_comment = 1'b0;
        res_a.last         = 1'b0;
        res_b.char_class   = st_b.in_block ? CLS_BLOCK : cls_b;
        res_b.open_comment = st_b.in_block;
        res_b.last         = 1'b1;
        push_a = in_fire && pend_valid_reg;
        push_b = in_fire && s_data.end_of_row;
        lex_next        = lex_reg;
        pend_valid_next = pend_valid_reg;
        if (in_fire) begin
            lex_next        = s_data.end_of_row ? st_b : st_mid;
            pend_valid_next = !s_data.end_of_row;
        end
    end

    // Result queue pointers and fill count.
    always_comb begin
        wr_ptr_b    = push_a ? (wr_ptr_reg + Q_PTR_W'(1)) : wr_ptr_reg;
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_a) + Q_PTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(out_fire);
        cnt_next    = cnt_reg + Q_CNT_W'(push_a) + Q_CNT_W'(push_b) - Q_CNT_W'(out_fire);
    end

    assign s_ready = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign m_valid = (cnt_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= CFG_RESET;
            lex_reg        <= LEX_RESET;
            pend_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            cfg_reg        <= cfg_next;
            lex_reg        <= lex_next;
            pend_valid_reg <= pend_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers: held character and queue entries.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pend_char_reg <= s_data.character;
        end
        if (push_a) begin
            q_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b) begin
            q_reg[wr_ptr_b] <= res_b;
        end
    end

    // The queue never holds more entries than it has.
    `SHLC_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= Q_CNT_W'(Q_DEPTH))
    // A row's final item leaves no character held back.
    `SHLC_ASSERT_NEXT(a_eor_flush, aclk, aresetn, in_fire && s_data.end_of_row, !pend_valid_reg)
    // An open comment is reported only on the row's last result, classed block comment.
    `SHLC_ASSERT_IMPL(a_open_last, aclk, aresetn, m_valid && m_data.open_comment,
        m_data.last && (m_data.char_class == CLS_BLOCK))
    // An item that releases a held character always produces a visible result.
    `SHLC_ASSERT_NEXT(a_pend_result, aclk, aresetn, in_fire && pend_valid_reg, m_valid)

endmodule

// File: test/syntax_highlight_classifier_checker.sv
`timescale 1ns / 1ps

module syntax_highlight_classifier_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  shlc_pkg::in_item_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  shlc_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [shlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shlc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatch_count,
    output int                                  results_pending,
    output int                                  results_checked
);
    import shlc_pkg::*;

    // Register values as last written.
    logic [1:0]  flags;
    logic [15:0] line_chars, open_chars, close_chars;
    logic [1:0]  line_len, open_len, close_len;

    // Lexer state: the held-back character and what the row has seen so far.
    logic [7:0] held_char;
    logic       held_valid;
    logic       in_block;
    quote_t     quote;
    logic       after_sep;
    cls_t       prev_cls;
    logic       forced_cnt;
    cls_t       forced_cls;
    logic       rest_row;

    out_item_t  expected_classes[$];
    out_item_t  want;

    // A delimiter longer than the lexer supports is cut down to what it supports.
    function automatic logic [1:0] clip_len(input logic [1:0] len);
        int l;
        l = len;
        if (l > DELIM_MAX) l = DELIM_MAX;
        if (l > 2) l = 2;
        return l[1:0];
    endfunction

    // The second delimiter byte must be the next character of the same row.
    function automatic logic delimiter_match(input logic [15:0] chars, input logic [1:0] len,
                                             input logic [7:0] c, input logic [7:0] n,
                                             input logic nv);
        logic [1:0] l;
        l = clip_len(len);
        if (l == 2'd0) return 1'b0;
        if (c != chars[7:0]) return 1'b0;
        if (l == 2'd2 && (!nv || n != chars[15:8])) return 1'b0;
        return 1'b1;
    endfunction

    // Characters that end a word, so that a following digit starts a number.
    function automatic logic word_break(input logic [7:0] c);
        string punct;
        punct = ",.()+-/*=~%<>[];";
        if (c == 8'h00 || c == " " || (c >= 8'h09 && c <= 8'h0D)) return 1'b1;
        for (int k = 0; k < punct.len(); k++) begin
            if (punct[k] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Class of one character, given the character after it when there is one.
    function automatic cls_t classify_char(input logic [7:0] c, input logic [7:0] n,
                                           input logic nv);
        cls_t cls;
        cls = CLS_NORMAL;
        if (forced_cnt) begin
            forced_cnt = 1'b0;
            cls = forced_cls;
        end else if (rest_row) begin
            cls = CLS_LINE;
        end else if (line_len != 2'd0 && quote == QUOTE_NONE && !in_block &&
                     delimiter_match(line_chars, line_len, c, n, nv)) begin
            rest_row = 1'b1;
            cls = CLS_LINE;
        end else if (clip_len(open_len) != 2'd0 && clip_len(close_len) != 2'd0 &&
                     quote == QUOTE_NONE &&
                     (in_block || delimiter_match(open_chars, open_len, c, n, nv))) begin
            cls = CLS_BLOCK;
            if (in_block) begin
                if (delimiter_match(close_chars, close_len, c, n, nv)) begin
                    in_block = 1'b0;
                    after_sep = 1'b1;
                    if (clip_len(close_len) == 2'd2) begin
                        forced_cnt = 1'b1;
                        forced_cls = CLS_BLOCK;
                    end
                end
            end else begin
                in_block = 1'b1;
                if (clip_len(open_len) == 2'd2) begin
                    forced_cnt = 1'b1;
                    forced_cls = CLS_BLOCK;
                end
            end
        end else if (flags[FLAG_STRING] && quote != QUOTE_NONE) begin
            cls = CLS_STRING;
            if (c == CHAR_BACKSLASH && nv) begin
                forced_cnt = 1'b1;
                forced_cls = CLS_STRING;
            end else begin
                if ((quote == QUOTE_DOUBLE && c == CHAR_DQUOTE) ||
                    (quote == QUOTE_SINGLE && c == CHAR_SQUOTE)) begin
                    quote = QUOTE_NONE;
                end
                after_sep = 1'b1;
            end
        end else if (flags[FLAG_STRING] && (c == CHAR_DQUOTE || c == CHAR_SQUOTE)) begin
            quote = (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
            cls = CLS_STRING;
        end else if (flags[FLAG_NUMBER] && c >= CHAR_ZERO && c <= CHAR_NINE &&
                     (after_sep || prev_cls == CLS_NUMBER)) begin
            cls = CLS_NUMBER;
            after_sep = 1'b0;
        end else begin
            after_sep = word_break(c);
            cls = CLS_NORMAL;
        end
        prev_cls = cls;
        return cls;
    endfunction

    // An accepted item releases the held character and, at the row end, itself.
    task automatic predict_item(input in_item_t it);
        out_item_t r;
        cls_t      cls;
        if (held_valid) begin
            r.char_class = classify_char(held_char, it.character, 1'b1);
            r.open_comment = 1'b0;
            r.last = 1'b0;
            expected_classes.push_back(r);
        end else begin
            quote = QUOTE_NONE;
            after_sep = 1'b1;
            prev_cls = CLS_NORMAL;
            forced_cnt = 1'b0;
            forced_cls = CLS_NORMAL;
            rest_row = 1'b0;
            if (it.first_row) in_block = 1'b0;
        end
        if (it.end_of_row) begin
            cls = classify_char(it.character, 8'h00, 1'b0);
            // A comment still open at the row end claims the last character.
            if (in_block) cls = CLS_BLOCK;
            r.char_class = cls;
            r.open_comment = in_block;
            r.last = 1'b1;
            expected_classes.push_back(r);
            held_valid = 1'b0;
            held_char = 8'h00;
        end else begin
            held_char = it.character;
            held_valid = 1'b1;
        end
    endtask

    task automatic log_mismatch(input string what, input out_item_t exp_r,
                                input out_item_t got);
        if (mismatch_count < 10) begin
            $display("%0t: %s: expected class %0d open %0b last %0b, got class %0d open %0b last %0b",
                     $time, what, exp_r.char_class, exp_r.open_comment, exp_r.last,
                     got.char_class, got.open_comment, got.last);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            flags = '0;
            line_chars = '0;
            line_len = '0;
            open_chars = '0;
            open_len = '0;
            close_chars = '0;
            close_len = '0;
            held_char = 8'h00;
            held_valid = 1'b0;
            in_block = 1'b0;
            quote = QUOTE_NONE;
            after_sep = 1'b1;
            prev_cls = CLS_NORMAL;
            forced_cnt = 1'b0;
            forced_cls = CLS_NORMAL;
            rest_row = 1'b0;
            expected_classes.delete();
            mismatch_count = 0;
            results_checked = 0;
        end else begin
            // Register writes apply to the items that follow them.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FEATURE_FLAGS: flags = cfg_wdata[1:0];
                    CFG_LINE_CHARS:    line_chars = cfg_wdata;
                    CFG_LINE_LEN:      line_len = cfg_wdata[1:0];
                    CFG_OPEN_CHARS:    open_chars = cfg_wdata;
                    CFG_OPEN_LEN:      open_len = cfg_wdata[1:0];
                    CFG_CLOSE_CHARS:   close_chars = cfg_wdata;
                    CFG_CLOSE_LEN:     close_len = cfg_wdata[1:0];
                    default: ;
                endcase
            end

            // Results leave in order, so each one belongs to the oldest prediction.
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_classes.size() == 0) begin
                    log_mismatch("result with nothing expected", '0, m_data);
                end else begin
                    want = expected_classes.pop_front();
                    if (m_data.char_class !== want.char_class ||
                        m_data.open_comment !== want.open_comment ||
                        m_data.last !== want.last) begin
                        log_mismatch("wrong result", want, m_data);
                    end
                end
            end

            // An item accepted at this edge can only produce results from the next one on.
            if (s_valid && s_ready) predict_item(s_data);
        end
        results_pending = expected_classes.size();
    end

endmodule

// File: test/syntax_highlight_classifier_core_tb.sv
`timescale 1ns / 1ps

module syntax_highlight_classifier_core_tb;
    import shlc_pkg::*;

    localparam int NUM_SETUPS = 7;
    localparam int ITEMS_PER_SETUP = 55;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT = 5000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int results_pending;
    int results_checked;

    int   items_sent = 0;
    int   holds_done = 0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;
    bit   hold_request = 1'b0;
    cfg_t setup = '0;
    cfg_t setups[NUM_SETUPS];
    cfg_t c_style;

    syntax_highlight_classifier_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    syntax_highlight_classifier_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the handshakes never complete.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    // Two-character delimiter; the first character sits in the low byte.
    function automatic logic [15:0] delim2(input logic [7:0] first, input logic [7:0] second);
        return {second, first};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [7:0] ch, input logic eor, input logic first);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{character: ch, end_of_row: eor, first_row: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Sends a whole row; bit i of first_mask drives first_row on character i.
    task automatic send_text(input string txt, input int first_mask);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], i == txt.len() - 1, first_mask[i]);
        end
    endtask

    // Random row built mostly from the bytes the current setup reacts to.
    task automatic send_random_row();
        logic [7:0] row[$];
        logic [7:0] spaces[7];
        string      punct;
        int         len;
        bit         first;
        punct = ",.()+-/*=~%<>[];";
        spaces = '{8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        while (row.size() < len) begin
            case ($urandom_range(0, 11))
                0: begin
                    row.push_back(setup.line_chars[7:0]);
                    row.push_back(setup.line_chars[15:8]);
                end
                1: begin
                    row.push_back(setup.open_chars[7:0]);
                    row.push_back(setup.open_chars[15:8]);
                end
                2: begin
                    row.push_back(setup.close_chars[7:0]);
                    row.push_back(setup.close_chars[15:8]);
                end
                3: begin
                    case ($urandom_range(0, 5))
                        0: row.push_back(setup.line_chars[7:0]);
                        1: row.push_back(setup.line_chars[15:8]);
                        2: row.push_back(setup.open_chars[7:0]);
                        3: row.push_back(setup.open_chars[15:8]);
                        4: row.push_back(setup.close_chars[7:0]);
                        default: row.push_back(setup.close_chars[15:8]);
                    endcase
                end
                4: row.push_back($urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE);
                5: row.push_back(CHAR_BACKSLASH);
                6: row.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                7: row.push_back(punct[$urandom_range(0, punct.len() - 1)]);
                8: row.push_back(spaces[$urandom_range(0, 6)]);
                11: row.push_back(8'($urandom_range(0, 255)));
                default: row.push_back(8'($urandom_range("a", "z")));
            endcase
        end
        first = ($urandom_range(0, 5) == 0);
        // first_row on a later character of the row must have no effect.
        foreach (row[i]) begin
            send_item(row[i], i == row.size() - 1,
                      (i == 0) ? first : ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_setup(input cfg_t s);
        setup = s;
        write_reg(CFG_FEATURE_FLAGS, CFG_DATA_W'(s.feature_flags));
        write_reg(CFG_LINE_CHARS, s.line_chars);
        write_reg(CFG_LINE_LEN, CFG_DATA_W'(s.line_len));
        write_reg(CFG_OPEN_CHARS, s.open_chars);
        write_reg(CFG_OPEN_LEN, CFG_DATA_W'(s.open_len));
        write_reg(CFG_CLOSE_CHARS, s.close_chars);
        write_reg(CFG_CLOSE_LEN, CFG_DATA_W'(s.close_len));
        cfg_wr_en <= 1'b0;
    endtask

    // Stop offering items and wait for every predicted result to come out.
    task automatic drain();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (results_pending != 0 && n < DRAIN_LIMIT) begin
            @(negedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stalls per item, plus one long hold-off on request.
    initial begin
        int wait_cycles;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end else begin
                wait_cycles = draw_gap(rx_steady);
                if (wait_cycles > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_cycles) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int start;
        c_style = '{2'd3, delim2("/", "/"), 2'd2, delim2("/", "*"), 2'd2,
                    delim2("*", "/"), 2'd2};
        // Block comments off, so a comment carried in from before goes stale.
        setups[0] = '{2'd0, delim2("/", "/"), 2'd2, delim2("/", "*"), 2'd0,
                      delim2("*", "/"), 2'd2};
        setups[1] = '{2'd3, delim2("#", 8'h00), 2'd1, delim2("{", 8'h00), 2'd1,
                      delim2("}", 8'h00), 2'd1};
        // Length three is cut to two; the line delimiter is two zero bytes.
        setups[2] = '{2'd1, 16'h0000, 2'd3, delim2("(", "*"), 2'd3,
                      delim2("*", ")"), 2'd2};
        setups[3] = '{2'd2, 16'hFFFF, 2'd2, 16'h0000, 2'd1, 16'hFFFF, 2'd1};
        setups[4] = '{2'd3, delim2("-", "-"), 2'd2, delim2("/", "*"), 2'd2,
                      delim2("*", "/"), 2'd1};
        setups[5] = '0;
        setups[6] = c_style;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows under C-style delimiters.
        load_setup(c_style);
        tx_steady = 1'b1;
        send_text("/*1", 1);              // opens a comment that stays open
        send_text("x*/9", 'b0010);        // carried comment closes, then a number
        send_text("\"\\\"'", 0);          // escaped quote inside an open string
        send_text("'a\\", 0);             // backslash at the row end
        send_text("b//", 0);              // line comment
        tx_steady = 1'b0;
        send_item(8'hFF, 1'b1, 1'b0);     // one-character rows at both byte extremes
        send_item(8'h00, 1'b1, 1'b1);
        send_text("1,2a3", 0);            // digits after separators and inside words
        send_text("/*", 0);               // left open for the next setup
        drain();

        // Random rows under each setup.
        for (int p = 0; p < NUM_SETUPS; p++) begin
            load_setup(setups[p]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                tx_steady = 1'b1;
                hold_request = 1'b1;
            end
            start = items_sent;
            while (items_sent - start < ITEMS_PER_SETUP) begin
                if ($urandom_range(0, 9) == 0) tx_steady = ~tx_steady;
                if ($urandom_range(0, 9) == 0) rx_steady = ~rx_steady;
                send_random_row();
            end
            drain();
        end

        $display("Run covered %0d items in %0d register setups; %0d results were compared.",
                 items_sent, NUM_SETUPS + 1, results_checked);
        $display("Result side held off %0d time(s) for %0d cycles while items kept coming.",
                 holds_done, HOLD_CYCLES);
        if (results_pending != 0) begin
            $display("%0d predicted results never came out.", results_pending);
        end
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
